// ===== rtl/tll_pkg.sv =====
package tll_pkg;

	localparam int LINE_BITS = 16;
	localparam int LEN_BITS  = 8;
	localparam int WORD_MAX  = 6;
	localparam int WBUF_BITS = 8 * WORD_MAX;
	localparam int NUM_RW    = 13;

	// Input operation codes
	localparam logic [1:0] OP_CHAR   = 2'd0;
	localparam logic [1:0] OP_EOL    = 2'd1;
	localparam logic [1:0] OP_EOI    = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Scanner modes
	localparam logic [3:0] M_START = 4'd0;
	localparam logic [3:0] M_ID    = 4'd1;
	localparam logic [3:0] M_INT   = 4'd2;
	localparam logic [3:0] M_DEC   = 4'd3;
	localparam logic [3:0] M_STR   = 4'd4;
	localparam logic [3:0] M_JUNK  = 4'd5;
	localparam logic [3:0] M_LCOM  = 4'd6;
	localparam logic [3:0] M_HASH  = 4'd7;
	localparam logic [3:0] M_STAR  = 4'd8;
	localparam logic [3:0] M_OP    = 4'd9;

	// Token classes
	localparam logic [4:0] C_WORD      = 5'd0;
	localparam logic [4:0] C_ID        = 5'd1;
	localparam logic [4:0] C_INT       = 5'd2;
	localparam logic [4:0] C_DEC       = 5'd3;
	localparam logic [4:0] C_STR       = 5'd4;
	localparam logic [4:0] C_PLUS      = 5'd5;
	localparam logic [4:0] C_MINUS     = 5'd6;
	localparam logic [4:0] C_MUL       = 5'd7;
	localparam logic [4:0] C_DIV       = 5'd8;
	localparam logic [4:0] C_MOD       = 5'd9;
	localparam logic [4:0] C_EQEQ      = 5'd10;
	localparam logic [4:0] C_NE        = 5'd11;
	localparam logic [4:0] C_LT        = 5'd12;
	localparam logic [4:0] C_LE        = 5'd13;
	localparam logic [4:0] C_GT        = 5'd14;
	localparam logic [4:0] C_GE        = 5'd15;
	localparam logic [4:0] C_ASSIGN    = 5'd16;
	localparam logic [4:0] C_NOT       = 5'd17;
	localparam logic [4:0] C_LPAREN    = 5'd18;
	localparam logic [4:0] C_RPAREN    = 5'd19;
	localparam logic [4:0] C_LBRACK    = 5'd20;
	localparam logic [4:0] C_RBRACK    = 5'd21;
	localparam logic [4:0] C_COMMA     = 5'd22;
	localparam logic [4:0] C_TILDE     = 5'd23;
	localparam logic [4:0] C_BAD_ID    = 5'd24;
	localparam logic [4:0] C_BAD_NUM   = 5'd25;
	localparam logic [4:0] C_OPEN_STR  = 5'd26;
	localparam logic [4:0] C_UNKNOWN   = 5'd27;
	localparam logic [4:0] C_OPEN_COM  = 5'd28;
	localparam logic [4:0] C_STRAY_END = 5'd29;
	localparam logic [4:0] C_FIRST_ERR = 5'd24;
	localparam logic [4:0] C_LAST      = 5'd29;

	typedef struct packed {
		logic [4:0]  cls;
		logic [15:0] line;
		logic [7:0]  len;
		logic        err;
		logic        last;
	} rec_t;

	// Reserved words, first byte in the low bits
	localparam logic [3:0] RW_LEN [NUM_RW] = '{
		4'd3, 4'd3, 4'd4, 4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5, 4'd3, 4'd4, 4'd5
	};
	localparam logic [47:0] RW_TXT [NUM_RW] = '{
		48'h00000000_6D756E,   // num
		48'h00000000_727473,   // str
		48'h000000_6C6F6F62,   // bool
		48'h00000000_006669,   // if
		48'h000000_65736C65,   // else
		48'h000000_706F6F6C,   // loop
		48'h0000_746E697270,   // print
		48'h00000000_666564,   // def
		48'h6E7275746572,      // return
		48'h0000_7472617473,   // start
		48'h00000000_646E65,   // end
		48'h000000_65757274,   // true
		48'h0000_65736C6166    // false
	};

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_opch(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
			c == "=" || c == "<" || c == ">" || c == "!";
	endfunction

	function automatic logic [4:0] sep_class(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		unique case (c)
			"(": r = C_LPAREN;
			")": r = C_RPAREN;
			"[": r = C_LBRACK;
			"]": r = C_RBRACK;
			",": r = C_COMMA;
			"~": r = C_TILDE;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Match the buffered prefix and length against every reserved word
	function automatic logic is_reserved(input logic [LEN_BITS-1:0] len,
			input logic [WBUF_BITS-1:0] buf_in);
		logic hit;
		logic same;
		hit = 1'b0;
		for (int w = 0; w < NUM_RW; w++) begin
			same = (len == LEN_BITS'(RW_LEN[w]));
			for (int k = 0; k < WORD_MAX && k < 6; k++) begin
				if (k < int'(RW_LEN[w]) && buf_in[8*k +: 8] != RW_TXT[w][8*k +: 8])
					same = 1'b0;
			end
			hit = hit | same;
		end
		return hit;
	endfunction

	function automatic logic [7:0] sat_len(input logic [LEN_BITS-1:0] len);
		logic [7:0] r;
		if (LEN_BITS > 8 && len > LEN_BITS'(255))
			r = 8'd255;
		else
			r = 8'(len);
		return r;
	endfunction

	function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] ln);
		logic [15:0] r;
		if (LINE_BITS > 16 && ln > LINE_BITS'(65535))
			r = 16'd65535;
		else
			r = 16'(ln);
		return r;
	endfunction

endpackage

// ===== rtl/toy_language_lexer_core.sv =====
// Streaming lexer: one request carries a character, an end of line or an end of
// input, and yields zero, one or two token records (class, line, length, error
// flag, last-of-request flag) in order. The scanner state updates in the cycle a
// request is accepted, so a request can be taken every clock while in_stall is
// low; records go into a four-entry result queue that drains one record per
// clock while out_stall is low. in_stall rises while fewer than two queue slots
// are free, so a stream averages one request per clock if each request yields
// at most one record and out_stall stays low. No clearing pass after reset.
module toy_language_lexer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] token_class,
	output logic [15:0] line_number,
	output logic [7:0] token_length,
	output logic       is_error,
	output logic       last_of_run
);
	import tll_pkg::*;

	logic [3:0]           mode_q, mode_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [LEN_BITS-1:0]  len_q, len_d, len_inc;
	logic [WBUF_BITS-1:0] wbuf_q, wbuf_d;
	logic [7:0]           pend_q, pend_d;
	logic                 inbc_q, inbc_d;
	logic                 star_q, star_d;
	logic                 dot_q, dot_d;
	logic                 alpha_q, alpha_d;

	logic                 f_v, s_v, do_start;
	logic [4:0]           f_cls, s_cls, single_cls, pair_cls;
	logic [LEN_BITS-1:0]  f_len;
	logic [7:0]           c;
	logic                 accept, pop;
	rec_t                 rec0, rec1;
	logic [1:0]           n_rec;

	rec_t                 mem [4];
	logic [1:0]           wr_q, rd_q;
	logic [2:0]           cnt_q;

	assign c       = char_code;
	assign accept  = in_valid && !in_stall;
	assign pop     = out_valid && !out_stall;
	assign len_inc = (len_q == {LEN_BITS{1'b1}}) ? len_q : len_q + 1'b1;

	// Classes of a held one-character operator
	always_comb begin
		priority case (pend_q)
			"=": begin single_cls = C_ASSIGN; pair_cls = C_EQEQ; end
			"!": begin single_cls = C_NOT;    pair_cls = C_NE;   end
			"<": begin single_cls = C_LT;     pair_cls = C_LE;   end
			default: begin single_cls = C_GT; pair_cls = C_GE;   end
		endcase
	end

	// Scanner next state and records
	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		len_d    = len_q;
		wbuf_d   = wbuf_q;
		pend_d   = pend_q;
		inbc_d   = inbc_q;
		star_d   = star_q;
		dot_d    = dot_q;
		alpha_d  = alpha_q;
		f_v      = 1'b0;
		f_cls    = C_ID;
		f_len    = len_q;
		do_start = 1'b0;
		s_v      = 1'b0;
		s_cls    = C_UNKNOWN;

		unique case (operation)
			OP_CHAR: begin
				if (inbc_q) begin
					if (star_q && c == "#") begin
						inbc_d = 1'b0;
						star_d = 1'b0;
						mode_d = M_START;
						len_d  = '0;
					end else begin
						star_d = (c == "*");
					end
				end else begin
					unique case (mode_q)
						M_ID: begin
							if (is_alpha(c) || is_digit(c) || c == "_") begin
								for (int k = 0; k < WORD_MAX; k++) begin
									if (len_q == LEN_BITS'(k))
										wbuf_d[8*k +: 8] = c;
								end
								len_d = len_inc;
							end else begin
								f_v      = 1'b1;
								f_cls    = is_reserved(len_q, wbuf_q) ? C_WORD : C_ID;
								do_start = 1'b1;
							end
						end
						M_INT: begin
							if (is_digit(c)) begin
								len_d = len_inc;
							end else if (c == ".") begin
								len_d  = len_inc;
								mode_d = M_DEC;
								dot_d  = 1'b1;
							end else if (is_alpha(c)) begin
								len_d   = len_inc;
								alpha_d = 1'b1;
								mode_d  = M_JUNK;
							end else begin
								f_v      = 1'b1;
								f_cls    = C_INT;
								do_start = 1'b1;
							end
						end
						M_DEC: begin
							if (is_digit(c)) begin
								len_d = len_inc;
								dot_d = 1'b0;
							end else if (c == ".") begin
								len_d   = len_inc;
								alpha_d = 1'b0;
								mode_d  = M_JUNK;
							end else if (is_alpha(c)) begin
								len_d   = len_inc;
								alpha_d = 1'b1;
								mode_d  = M_JUNK;
							end else begin
								f_v      = 1'b1;
								f_cls    = dot_q ? C_BAD_NUM : C_DEC;
								do_start = 1'b1;
							end
						end
						M_JUNK: begin
							if (!is_opch(c) && sep_class(c) == 5'd0) begin
								len_d = len_inc;
								if (is_alpha(c) || c == "_")
									alpha_d = 1'b1;
							end else begin
								f_v      = 1'b1;
								f_cls    = alpha_q ? C_BAD_ID : C_BAD_NUM;
								do_start = 1'b1;
							end
						end
						M_STR: begin
							if (c == "\"") begin
								f_v    = 1'b1;
								f_cls  = C_STR;
								f_len  = len_inc;
								mode_d = M_START;
								len_d  = '0;
							end else if (c == 8'd0) begin
								f_v    = 1'b1;
								f_cls  = C_OPEN_STR;
								mode_d = M_START;
								len_d  = '0;
							end else begin
								len_d = len_inc;
							end
						end
						M_LCOM: begin
						end
						M_HASH: begin
							if (c == "*") begin
								inbc_d = 1'b1;
								star_d = 1'b0;
								mode_d = M_START;
								len_d  = '0;
							end else begin
								mode_d = M_LCOM;
							end
						end
						M_STAR: begin
							f_v = 1'b1;
							if (c == "#") begin
								f_cls  = C_STRAY_END;
								f_len  = '0;
								mode_d = M_START;
								len_d  = '0;
							end else begin
								f_cls    = C_MUL;
								f_len    = LEN_BITS'(1);
								do_start = 1'b1;
							end
						end
						M_OP: begin
							f_v = 1'b1;
							if (c == "=") begin
								f_cls  = pair_cls;
								f_len  = LEN_BITS'(2);
								mode_d = M_START;
								len_d  = '0;
							end else begin
								f_cls    = single_cls;
								f_len    = LEN_BITS'(1);
								do_start = 1'b1;
							end
						end
						default: do_start = 1'b1;
					endcase
				end

				// Begin a new token with this character
				if (do_start) begin
					mode_d = M_START;
					len_d  = '0;
					if (is_space(c) || c == 8'd0) begin
					end else if (is_alpha(c) || c == "_") begin
						mode_d = M_ID;
						len_d  = LEN_BITS'(1);
						wbuf_d = WBUF_BITS'(c);
					end else if (is_digit(c)) begin
						mode_d = M_INT;
						len_d  = LEN_BITS'(1);
						dot_d  = 1'b0;
					end else if (c == "\"") begin
						mode_d = M_STR;
						len_d  = LEN_BITS'(1);
					end else if (c == "#") begin
						mode_d = M_HASH;
					end else if (c == "*") begin
						mode_d = M_STAR;
					end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
						mode_d = M_OP;
						pend_d = c;
					end else begin
						s_v = 1'b1;
						priority if (c == "+") s_cls = C_PLUS;
						else if (c == "-") s_cls = C_MINUS;
						else if (c == "/") s_cls = C_DIV;
						else if (c == "%") s_cls = C_MOD;
						else if (sep_class(c) != 5'd0) s_cls = sep_class(c);
						else s_cls = C_UNKNOWN;
					end
				end
			end
			OP_EOL, OP_EOI: begin
				// Close the open token at the end of the line or of the input
				if (!inbc_q) begin
					f_v = 1'b1;
					unique case (mode_q)
						M_ID:   f_cls = is_reserved(len_q, wbuf_q) ? C_WORD : C_ID;
						M_INT:  f_cls = C_INT;
						M_DEC:  f_cls = dot_q ? C_BAD_NUM : C_DEC;
						M_JUNK: f_cls = alpha_q ? C_BAD_ID : C_BAD_NUM;
						M_STR:  f_cls = C_OPEN_STR;
						M_STAR: begin f_cls = C_MUL; f_len = LEN_BITS'(1); end
						M_OP:   begin f_cls = single_cls; f_len = LEN_BITS'(1); end
						default: f_v = 1'b0;
					endcase
				end
				mode_d  = M_START;
				len_d   = '0;
				star_d  = 1'b0;
				dot_d   = 1'b0;
				alpha_d = 1'b0;
				wbuf_d  = '0;
				pend_d  = '0;
				if (operation == OP_EOL) begin
					if (line_q != {LINE_BITS{1'b1}})
						line_d = line_q + 1'b1;
				end else begin
					if (inbc_q) begin
						s_v   = 1'b1;
						s_cls = C_OPEN_COM;
					end
					line_d = LINE_BITS'(1);
					inbc_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Pack the records of this request in order
	always_comb begin
		rec_t fr, sr;
		fr.cls  = f_cls;
		fr.line = sat_line(line_q);
		fr.len  = sat_len(f_len);
		fr.err  = (f_cls >= C_FIRST_ERR);
		fr.last = !s_v;
		sr.cls  = s_cls;
		sr.line = sat_line(line_q);
		sr.len  = (s_cls == C_OPEN_COM) ? 8'd0 : 8'd1;
		sr.err  = (s_cls >= C_FIRST_ERR);
		sr.last = 1'b1;
		rec0    = f_v ? fr : sr;
		rec1    = sr;
		n_rec   = {1'b0, f_v} + {1'b0, s_v};
	end

	// Advance scanner state on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_START;
			line_q  <= LINE_BITS'(1);
			len_q   <= '0;
			wbuf_q  <= '0;
			pend_q  <= '0;
			inbc_q  <= 1'b0;
			star_q  <= 1'b0;
			dot_q   <= 1'b0;
			alpha_q <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			line_q  <= line_d;
			len_q   <= len_d;
			wbuf_q  <= wbuf_d;
			pend_q  <= pend_d;
			inbc_q  <= inbc_d;
			star_q  <= star_d;
			dot_q   <= dot_d;
			alpha_q <= alpha_d;
		end
	end

	// Result queue: push up to two records, pop one
	always_ff @(posedge clk) begin
		if (accept && n_rec != 2'd0)
			mem[wr_q] <= rec0;
		if (accept && n_rec == 2'd2)
			mem[wr_q + 2'd1] <= rec1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept)
				wr_q <= wr_q + n_rec;
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + (accept ? {1'b0, n_rec} : 3'd0) - {2'b0, pop};
		end
	end

	assign in_stall     = (cnt_q > 3'd2);
	assign out_valid    = (cnt_q != 3'd0);
	assign token_class  = mem[rd_q].cls;
	assign line_number  = mem[rd_q].line;
	assign token_length = mem[rd_q].len;
	assign is_error     = mem[rd_q].err;
	assign last_of_run  = mem[rd_q].last;

endmodule

// ===== rtl/tll_checker.sv =====
module tll_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  token_class,
	input logic [15:0] line_number,
	input logic        is_error
);
	import tll_pkg::*;

	// Hold a stalled record
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_class))
		else $error("stalled record changed");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_error == (token_class >= C_FIRST_ERR))
		else $error("error flag disagrees with class");

	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != 16'd0)
		else $error("line number zero");

	a_cls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_class <= C_LAST)
		else $error("class out of range");

endmodule

bind toy_language_lexer_core tll_checker u_tll_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.token_class(token_class),
	.line_number(line_number),
	.is_error(is_error)
);
